### design/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, idle during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

### design/padsr_pkg.sv
`timescale 1ns / 1ps
package padsr_pkg;

  localparam int unsigned VOICES_DEF = 8;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_CTRL     = 4'hb;

  localparam logic [6:0] CC_ATK_LEN  = 7'h0c;
  localparam logic [6:0] CC_DEC_LEN  = 7'h0d;
  localparam logic [6:0] CC_SUS_LVL  = 7'h0e;
  localparam logic [6:0] CC_REL_LEN  = 7'h0f;
  localparam logic [6:0] CC_ATK_MULT = 7'h16;
  localparam logic [6:0] CC_DEC_MULT = 7'h17;
  localparam logic [6:0] CC_REL_MULT = 7'h19;

  localparam logic [6:0]  MULT_RST = 7'd32;
  localparam logic [15:0] FULL_LVL = 16'd32767;

  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_ON      = 3'd1,
    PH_ATTACK  = 3'd2,
    PH_DECAY   = 3'd3,
    PH_SUSTAIN = 3'd4,
    PH_RELEASE = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ZERO = 3'd1,
    OP_ATK  = 3'd2,
    OP_DEC  = 3'd3,
    OP_SUS  = 3'd4,
    OP_REL  = 3'd5
  } op_t;

endpackage

### design/polyphonic_adsr_voice_engine_top.sv
`timescale 1ns / 1ps
// Polyphonic ADSR envelope engine. Input words carry either a MIDI message
// (in_tuser = 0) or the raw oscillator sample of the next voice in order
// (in_tuser = 1). Note-on takes the lowest free voice, note-off releases the
// lowest active voice with matching note and channel, and control changes set
// per-channel envelope lengths, sustain level and multipliers. Each active
// voice's sample is shaped by its envelope; after the last voice's sample one
// output word carries the sum divided by VOICES, truncated toward zero.
// One item is in flight at a time (in_tready low while busy). Envelope
// arithmetic runs through one shared 17x17 multiplier and one radix-2 divider
// that retires one quotient bit per cycle over 33 steps. The final average
// uses a constant reciprocal multiply in the output state. A control change
// ends at message decode; note-on/off scan the voices in order until a hit or
// the last voice. A sample for an off voice skips the multiplier, sustain
// multiplies once, and attack, decay and release also divide. The last
// voice's sample also passes through the output state, which loads the
// output register and waits there while the previous output word has not
// yet been taken. A finished result waits in the output register, so input
// goes on while it is pending.
module polyphonic_adsr_voice_engine_top #(
  parameter int unsigned VOICES = padsr_pkg::VOICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // [7:0] status_byte, [14:8] data_one, [21:15] data_two,
  // [37:22] osc_sample, [39:38] zero
  input  logic [padsr_pkg::IN_DATA_W-1:0]    in_tdata,
  // [0] action
  input  logic [padsr_pkg::IN_USER_W-1:0]    in_tuser,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] mixed_sample
  output logic [padsr_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready
);
  import padsr_pkg::*;

`include "assert_macros.svh"

  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam logic [VW-1:0] LAST_V = VW'(VOICES - 1);
  localparam logic [5:0] DIV_STEPS = 6'd33;
  // exact floor division by VOICES for magnitudes below 2^22
  localparam int unsigned RCP_SH = 28;
  localparam logic [28:0] RCP_MUL =
    29'(((64'd1 << RCP_SH) + 64'(VOICES) - 64'd1) / 64'(VOICES));

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_MSG      = 12'b000000000010,
    S_SCAN_RD  = 12'b000000000100,
    S_SCAN_CHK = 12'b000000001000,
    S_SMP_RD   = 12'b000000010000,
    S_EVAL     = 12'b000000100000,
    S_MUL_SH   = 12'b000001000000,
    S_MUL_DV   = 12'b000010000000,
    S_DIV      = 12'b000100000000,
    S_ACC      = 12'b001000000000,
    S_OUT      = 12'b010000000000,
    S_SPARE    = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  // latched input word
  logic [7:0]  status_r;
  logic [6:0]  d1_r, d2_r;
  logic        action_r;

  // voice store
  phase_t      ph_mem   [VOICES];
  logic [6:0]  note_mem [VOICES];
  logic [3:0]  chan_mem [VOICES];
  logic [15:0] acnt_mem [VOICES];
  logic [15:0] dcnt_mem [VOICES];
  logic [15:0] rcnt_mem [VOICES];

  phase_t      rd_ph;
  logic [6:0]  rd_note;
  logic [3:0]  rd_chan;
  logic [15:0] rd_acnt, rd_dcnt, rd_rcnt;

  // channel settings
  logic [15:0] alen_r [16];
  logic [15:0] dlen_r [16];
  logic [15:0] rlen_r [16];
  logic [14:0] sus_r  [16];
  logic [6:0]  amul_r [16];
  logic [6:0]  dmul_r [16];
  logic [6:0]  rmul_r [16];

  logic [VW-1:0] vidx_r, cursor_r;
  logic signed [31:0] mix_r;
  logic signed [16:0] s_r, ma_r;
  logic [15:0] mb_r, db_r, den_r;
  op_t         op_r;
  logic        active_r;

  // divider
  logic [32:0] quo_r;
  logic [16:0] rem_r;
  logic        neg_r;
  logic [5:0]  div_cnt_r;

  logic [15:0] out_r;
  logic        out_valid_r;

  // ---------------- decode ----------------
  logic [3:0] cmd, ch;
  logic       is_on, is_off;
  assign cmd    = status_r[7:4];
  assign ch     = status_r[3:0];
  assign is_on  = (cmd == CMD_NOTE_ON) && (d2_r != 7'd0);
  assign is_off = (cmd == CMD_NOTE_OFF) || ((cmd == CMD_NOTE_ON) && (d2_r == 7'd0));

  logic scan_hit;
  always_comb begin
    if (is_on) scan_hit = (rd_ph == PH_OFF);
    else       scan_hit = (rd_ph != PH_OFF) && (rd_note == d1_r) && (rd_chan == ch);
  end

  // ---------------- envelope decision ----------------
  logic [15:0] e_alen, e_dlen, e_rlen;
  logic [14:0] e_sus;
  phase_t      e_ph;
  op_t         e_op;
  logic [15:0] e_acnt, e_dcnt, e_rcnt;

  always_comb begin
    e_alen = alen_r[rd_chan];
    e_dlen = dlen_r[rd_chan];
    e_rlen = rlen_r[rd_chan];
    e_sus  = sus_r[rd_chan];
    e_ph   = rd_ph;
    e_op   = OP_NONE;
    e_acnt = rd_acnt;
    e_dcnt = rd_dcnt;
    e_rcnt = rd_rcnt;
    if (e_ph == PH_ON) e_ph = PH_ATTACK;
    if (e_ph == PH_ATTACK) begin
      if (e_alen != 16'd0 && rd_acnt < e_alen) begin
        e_op   = OP_ATK;
        e_acnt = rd_acnt + 16'd1;
      end else begin
        e_ph = PH_DECAY;
      end
    end
    if (e_ph == PH_DECAY) begin
      if (e_dlen != 16'd0 && rd_dcnt < e_dlen) begin
        e_op   = OP_DEC;
        e_dcnt = rd_dcnt + 16'd1;
      end else begin
        e_ph = PH_SUSTAIN;
      end
    end
    if (e_ph == PH_SUSTAIN && e_sus != 15'd0) e_op = OP_SUS;
    if (e_ph == PH_RELEASE) begin
      if (e_rlen != 16'd0 && rd_rcnt < e_rlen) begin
        e_op   = OP_REL;
        e_rcnt = rd_rcnt + 16'd1;
      end else begin
        e_ph = PH_OFF;
        e_op = OP_ZERO;
      end
    end
  end

  // ---------------- shared multiplier ----------------
  logic signed [16:0] mul_a;
  logic [15:0]        mul_b;
  logic signed [33:0] prod;
  always_comb begin
    if (state_r == S_MUL_SH) begin
      mul_a = s_r;
      mul_b = mb_r;
    end else begin
      mul_a = ma_r;
      mul_b = db_r;
    end
  end
  assign prod = 34'(mul_a) * 34'($signed({1'b0, mul_b}));

  logic [33:0] prod_mag;
  assign prod_mag = prod[33] ? 34'(-prod) : 34'(prod);

  // ---------------- divider step ----------------
  logic [16:0] rem_sh;
  logic        q_bit;
  logic [16:0] rem_new;
  logic signed [33:0] q_signed;
  assign rem_sh  = {rem_r[15:0], quo_r[32]};
  assign q_bit   = (rem_sh >= {1'b0, den_r});
  assign rem_new = q_bit ? (rem_sh - {1'b0, den_r}) : rem_sh;
  assign q_signed = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});

  // accumulate
  logic signed [31:0] sum;
  logic signed [31:0] sum_mag;
  assign sum     = mix_r + (active_r ? 32'(s_r) : 32'sd0);
  assign sum_mag = sum[31] ? -sum : sum;

  // average: magnitude of the frame sum times the reciprocal of VOICES
  logic [50:0] avg_prod;
  logic [15:0] avg_mag, avg_res;
  assign avg_prod = 51'(quo_r[21:0]) * 51'(RCP_MUL);
  assign avg_mag  = 16'(avg_prod[50:RCP_SH]);
  assign avg_res  = neg_r ? 16'(-avg_mag) : avg_mag;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_tvalid) state_nxt = in_tuser[0] ? S_SMP_RD : S_MSG;
      S_MSG:      state_nxt = (is_on || is_off) ? S_SCAN_RD : S_IDLE;
      S_SCAN_RD:  state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: state_nxt = (scan_hit || vidx_r == LAST_V) ? S_IDLE : S_SCAN_RD;
      S_SMP_RD:   state_nxt = S_EVAL;
      S_EVAL: begin
        if (rd_ph == PH_OFF) state_nxt = S_ACC;
        else begin
          case (e_op)
            OP_ATK, OP_DEC: state_nxt = S_MUL_DV;
            OP_SUS, OP_REL: state_nxt = S_MUL_SH;
            default:        state_nxt = S_ACC;
          endcase
        end
      end
      S_MUL_SH:   state_nxt = (op_r == OP_REL) ? S_MUL_DV : S_ACC;
      S_MUL_DV:   state_nxt = S_DIV;
      S_DIV: begin
        if (div_cnt_r == 6'd0) begin
          if (op_r == OP_DEC) state_nxt = S_MUL_SH;
          else                state_nxt = S_ACC;
        end
      end
      S_ACC:      state_nxt = (cursor_r == LAST_V) ? S_OUT : S_IDLE;
      S_OUT:      if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tdata  = out_r;
  assign out_tvalid = out_valid_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cursor_r    <= '0;
      mix_r       <= '0;
      out_valid_r <= 1'b0;
      div_cnt_r   <= '0;
      vidx_r      <= '0;
    end else begin
      state_r <= state_nxt;
      // load a new word when the register is free or being drained
      if (state_r == S_OUT && (!out_valid_r || out_tready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_tready)                    out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          vidx_r <= in_tvalid && in_tuser[0] ? cursor_r : '0;
        end
        S_SCAN_CHK: begin
          if (!scan_hit && vidx_r != LAST_V) vidx_r <= vidx_r + VW'(1);
        end
        S_MUL_DV: begin
          div_cnt_r <= DIV_STEPS;
        end
        S_DIV: begin
          if (div_cnt_r != 6'd0) div_cnt_r <= div_cnt_r - 6'd1;
        end
        S_ACC: begin
          if (cursor_r == LAST_V) begin
            mix_r    <= '0;
            cursor_r <= '0;
          end else begin
            mix_r    <= sum;
            cursor_r <= cursor_r + VW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (in_tvalid) begin
        status_r <= in_tdata[7:0];
        d1_r     <= in_tdata[14:8];
        d2_r     <= in_tdata[21:15];
        s_r      <= 17'(signed'(in_tdata[37:22]));
        action_r <= in_tuser[0];
      end
      S_EVAL: begin
        op_r     <= e_op;
        active_r <= (rd_ph != PH_OFF);
        den_r    <= (e_op == OP_ATK) ? e_alen : (e_op == OP_DEC) ? e_dlen : e_rlen;
        mb_r     <= 16'(e_sus);
        db_r     <= (e_op == OP_ATK) ? e_acnt : (e_op == OP_DEC) ? rd_dcnt
                                                 : 16'(e_rlen - rd_rcnt);
        ma_r     <= (e_op == OP_DEC) ? 17'(FULL_LVL - 16'(e_sus)) : s_r;
        if (e_op == OP_ZERO) s_r <= '0;
      end
      S_MUL_SH: begin
        s_r  <= prod[31:15];
        ma_r <= prod[31:15];
      end
      S_MUL_DV: begin
        neg_r <= prod[33];
        quo_r <= prod_mag[32:0];
        rem_r <= '0;
      end
      S_DIV: begin
        if (div_cnt_r != 6'd0) begin
          rem_r <= rem_new;
          quo_r <= {quo_r[31:0], q_bit};
        end else if (op_r == OP_DEC) begin
          mb_r <= 16'(FULL_LVL - q_signed[15:0]);
        end else begin
          s_r <= q_signed[16:0];
        end
      end
      S_ACC: begin
        neg_r <= sum[31];
        quo_r <= 33'(unsigned'(sum_mag));
      end
      S_OUT: if (!out_valid_r || out_tready) out_r <= avg_res;
      default: ;
    endcase
  end

  // voice store: registered read at vidx_r, writes on scan hit or envelope step
  always_ff @(posedge clk) begin
    rd_ph   <= ph_mem[vidx_r];
    rd_note <= note_mem[vidx_r];
    rd_chan <= chan_mem[vidx_r];
    rd_acnt <= acnt_mem[vidx_r];
    rd_dcnt <= dcnt_mem[vidx_r];
    rd_rcnt <= rcnt_mem[vidx_r];
    if (state_r == S_SCAN_CHK && scan_hit && is_on) begin
      note_mem[vidx_r] <= d1_r;
      chan_mem[vidx_r] <= ch;
      acnt_mem[vidx_r] <= '0;
      dcnt_mem[vidx_r] <= '0;
      rcnt_mem[vidx_r] <= '0;
    end
    if (state_r == S_EVAL && rd_ph != PH_OFF) begin
      acnt_mem[vidx_r] <= e_acnt;
      dcnt_mem[vidx_r] <= e_dcnt;
      rcnt_mem[vidx_r] <= e_rcnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICES; i++) ph_mem[i] <= PH_OFF;
    end else if (state_r == S_SCAN_CHK && scan_hit) begin
      ph_mem[vidx_r] <= is_on ? PH_ON : PH_RELEASE;
    end else if (state_r == S_EVAL && rd_ph != PH_OFF) begin
      ph_mem[vidx_r] <= e_ph;
    end
  end

  // channel settings: apply control change
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        alen_r[i] <= '0;
        dlen_r[i] <= '0;
        rlen_r[i] <= '0;
        sus_r[i]  <= '0;
        amul_r[i] <= MULT_RST;
        dmul_r[i] <= MULT_RST;
        rmul_r[i] <= MULT_RST;
      end
    end else if (state_r == S_MSG && cmd == CMD_CTRL && !action_r) begin
      unique case (d1_r)
        CC_ATK_LEN:  alen_r[ch] <= 16'(amul_r[ch]) * 16'(d2_r);
        CC_DEC_LEN:  dlen_r[ch] <= 16'(dmul_r[ch]) * 16'(d2_r);
        CC_REL_LEN:  rlen_r[ch] <= 16'(rmul_r[ch]) * 16'(d2_r);
        CC_SUS_LVL:  sus_r[ch]  <= {d2_r, {8{d2_r[0]}}};
        CC_ATK_MULT: amul_r[ch] <= d2_r;
        CC_DEC_MULT: dmul_r[ch] <= d2_r;
        CC_REL_MULT: rmul_r[ch] <= d2_r;
        default: ;
      endcase
    end
  end

  `ASSERT_IMPL(a_div_only_in_div, clk, rst_n, div_cnt_r != 6'd0, state_r == S_DIV)
  `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `ASSERT_IMPL(a_out_at_frame_end, clk, rst_n, $rose(out_valid_r), cursor_r == '0)

endmodule
